@@ rtl/pdat_pkg.sv @@
`timescale 1ns / 1ps
package pdat_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = (CW > 4) ? CW : 4;
  localparam int MAX_RESULTS = 16;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  // time of day
  localparam logic [18:0] DAY_SECONDS = 19'd86400;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // one decoded command as it sits in the queue
  typedef struct packed {
    op_t         op;
    logic [16:0] now;
    logic [3:0]  slot;
    logic [16:0] first;
    logic [15:0] len;
  } cmd_t;

  // back end status seen by the top level
  typedef struct packed {
    logic          idle;
    logic [CW-1:0] count;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_CLR,
    ST_SCAN,
    ST_DIV,
    ST_CATCH,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/periodic_daily_alarm_table.sv @@
`timescale 1ns / 1ps
// Daily alarm table.
// Input channel (in_valid/in_ready) carries op, now_seconds, slot,
// first_second and run_length; a two-entry command queue takes a
// transaction while the table engine is still busy with an earlier one.
// Output channel (out_valid/out_ready) returns one transaction per firing,
// fired_slot and fired_length in table order, last set on the final firing
// of a tick; a tick with no firing returns nothing.
// repeat_interval is written through cfg_write_en/cfg_write_data.
// The engine handles one command at a time. A tick checks each entry in
// turn; an overdue entry goes through a scan step, a bit-serial remainder
// of 17 steps and an update. Insert and remove shift entries one at a time,
// and clear walks every entry. A firing is held one entry behind in a pending
// register so that the last flag is known when it leaves.
// Reset empties the table and the queue and sets repeat_interval to zero.
// A stalled receiver holds the output register; the scan pauses on its
// next firing until that register frees up.
module periodic_daily_alarm_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [16:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [16:0] now_seconds,
  input  logic [3:0]  slot,
  input  logic [16:0] first_second,
  input  logic [15:0] run_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  fired_slot,
  output logic [15:0] fired_length,
  output logic        last
);
  import pdat_pkg::*;

  logic         [16:0] repeat_interval;
  logic                cmd_valid;
  logic                cmd_ready;
  cmd_t                cmd;
  back_status_t        status;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= 17'd0;
    end else if (cfg_write_en) begin
      repeat_interval <= cfg_write_data;
    end
  end

  pdat_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .now_seconds  (now_seconds),
    .slot         (slot),
    .first_second (first_second),
    .run_length   (run_length),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  pdat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .interval     (repeat_interval),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fired_slot   (fired_slot),
    .fired_length (fired_length),
    .last         (last),
    .status       (status)
  );

  // table never grows past its size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    status.count <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (status.count == $past(status.count)) ||
    (status.count == $past(status.count) + CW'(1)) ||
    (status.count == $past(status.count) - CW'(1)))
    else $error("entry count jumped");

  // commands leave the queue only into an idle engine
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> status.idle)
    else $error("command taken while engine busy");

  // count changes only while a command is at work
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    ($past(status.idle) && !$past(cmd_valid && cmd_ready)) |-> $stable(status.count))
    else $error("count changed with no command");

endmodule

@@ rtl/pdat_front.sv @@
`timescale 1ns / 1ps
module pdat_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  input  logic [16:0]          now_seconds,
  input  logic [3:0]           slot,
  input  logic [16:0]          first_second,
  input  logic [15:0]          run_length,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output pdat_pkg::cmd_t       cmd
);
  import pdat_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  // classify the incoming transaction
  always_comb begin
    incoming.op    = op_t'(op);
    incoming.now   = now_seconds;
    incoming.slot  = slot;
    incoming.first = first_second;
    incoming.len   = run_length;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // two deep command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/pdat_back.sv @@
`timescale 1ns / 1ps
module pdat_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [16:0]            interval,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  pdat_pkg::cmd_t         cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             fired_slot,
  output logic [15:0]            fired_length,
  output logic                   last,
  output pdat_pkg::back_status_t status
);
  import pdat_pkg::*;

  // entry storage
  logic [16:0] start_mem  [MAX_ENTRIES];
  logic [15:0] length_mem [MAX_ENTRIES];
  logic [16:0] offset_mem [MAX_ENTRIES];

  state_t        state;
  state_t        state_next;
  cmd_t          cur;
  logic [CW-1:0] idx;
  logic [CW-1:0] cnt;
  logic [CW-1:0] pos;
  logic          pend_valid;
  logic [3:0]    pend_slot;
  logic [15:0]   pend_len;
  logic [RW-1:0] fire_n;
  logic [16:0]   dvd;
  logic [16:0]   rem;
  logic [4:0]    step;
  logic [17:0]   run_r;
  logic [16:0]   diff_r;
  logic [16:0]   off_r;

  // read and write port
  logic [IW-1:0] rd_addr;
  logic [16:0]   rd_start;
  logic [15:0]   rd_len;
  logic [16:0]   rd_off;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [16:0]   wr_start;
  logic [15:0]   wr_len;
  logic [16:0]   wr_off;

  // decode helpers
  logic          out_free;
  logic          out_load;
  logic [17:0]   run;
  logic          hit;
  logic          late;
  logic          report;
  logic          stall;
  logic [18:0]   step_sum;
  logic [16:0]   fire_off;
  logic [17:0]   rem_sh;
  logic [16:0]   pad;
  logic [17:0]   stride;
  logic [18:0]   catch_sum;
  logic [16:0]   catch_off;
  logic [CW-1:0] ins_pos;
  logic          cmd_take;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;

  assign rd_start = start_mem[rd_addr];
  assign rd_len   = length_mem[rd_addr];
  assign rd_off   = offset_mem[rd_addr];

  // scan step arithmetic
  assign run      = {1'b0, rd_start} + {1'b0, rd_off};
  assign hit      = (idx != cnt) && (run == {1'b0, cur.now});
  assign late     = (idx != cnt) && (interval != 17'd0) && (run < {1'b0, cur.now});
  assign report   = (fire_n < RW'(MAX_RESULTS));
  assign stall    = hit && report && pend_valid && !out_free;
  assign step_sum = {1'b0, run} + {2'b00, interval};
  assign fire_off = (step_sum < DAY_SECONDS) ? (rd_off + interval) : 17'd0;

  // output register loads on a passed-on firing or the final flush
  assign out_load = ((state == ST_SCAN) && hit && !stall && report && pend_valid) ||
                    ((state == ST_FLUSH) && out_free);

  // catch-up remainder and new offset
  assign rem_sh    = {rem, dvd[16]};
  assign pad       = (rem == 17'd0) ? 17'd0 : (interval - rem);
  assign stride    = {1'b0, diff_r} + {1'b0, pad};
  assign catch_sum = {1'b0, run_r} + {1'b0, stride};
  assign catch_off = (catch_sum < DAY_SECONDS) ? 17'(({1'b0, off_r} + stride)) : 17'd0;

  assign ins_pos = (SW'(cmd.slot) > SW'(cnt)) ? cnt : CW'(cmd.slot);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          case (cmd.op)
            OP_TICK:   state_next = ST_SCAN;
            OP_INSERT: state_next = (cnt < CW'(MAX_ENTRIES)) ? ST_INS : ST_IDLE;
            OP_REMOVE: state_next = (SW'(cmd.slot) < SW'(cnt)) ? ST_REM : ST_IDLE;
            default:   state_next = ST_CLR;
          endcase
        end
      end
      ST_INS:   if (idx <= pos) state_next = ST_IDLE;
      ST_REM:   if (idx + CW'(1) >= cnt) state_next = ST_IDLE;
      ST_CLR:   if (idx == cnt) state_next = ST_IDLE;
      ST_SCAN: begin
        if (idx == cnt) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end else if (!hit && late) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:   if (step == 5'd16) state_next = ST_CATCH;
      ST_CATCH: state_next = ST_SCAN;
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr  = idx[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = idx[IW-1:0];
    wr_start = rd_start;
    wr_len   = rd_len;
    wr_off   = rd_off;
    case (state)
      ST_INS: begin
        wr_en = 1'b1;
        if (idx > pos) begin
          rd_addr = IW'(idx - CW'(1));
        end else begin
          wr_start = cur.first;
          wr_len   = cur.len;
          wr_off   = 17'd0;
        end
      end
      ST_REM: begin
        rd_addr = IW'(idx + CW'(1));
        wr_en   = (idx + CW'(1) < cnt);
      end
      ST_CLR: begin
        wr_en  = (idx != cnt);
        wr_off = 17'd0;
      end
      ST_SCAN: begin
        wr_en  = hit && !stall && (interval != 17'd0);
        wr_off = fire_off;
      end
      ST_CATCH: begin
        wr_en  = 1'b1;
        wr_off = catch_off;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr]  <= wr_start;
      length_mem[wr_addr] <= wr_len;
      offset_mem[wr_addr] <= wr_off;
    end
  end

  // command capture and divider datapath
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
      pos <= ins_pos;
    end
    if (state == ST_SCAN && late && !hit) begin
      run_r  <= run;
      diff_r <= cur.now - run[16:0];
      off_r  <= rd_off;
      dvd    <= cur.now - run[16:0];
      rem    <= 17'd0;
      step   <= 5'd0;
    end else if (state == ST_DIV) begin
      rem  <= (rem_sh >= {1'b0, interval}) ? 17'(rem_sh - {1'b0, interval}) : rem_sh[16:0];
      dvd  <= {dvd[15:0], 1'b0};
      step <= step + 5'd1;
    end
  end

  // control registers, pending result and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      fire_n     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            fire_n <= '0;
            case (cmd.op)
              OP_INSERT: idx <= cnt;
              OP_REMOVE: idx <= CW'(cmd.slot);
              default:   idx <= '0;
            endcase
          end
        end
        ST_INS: begin
          if (idx > pos) idx <= idx - CW'(1);
          else cnt <= cnt + CW'(1);
        end
        ST_REM: begin
          if (idx + CW'(1) < cnt) idx <= idx + CW'(1);
          else cnt <= cnt - CW'(1);
        end
        ST_CLR: begin
          if (idx != cnt) idx <= idx + CW'(1);
        end
        ST_SCAN: begin
          if (hit && !stall) begin
            idx <= idx + CW'(1);
            if (report) begin
              fire_n     <= fire_n + RW'(1);
              pend_valid <= 1'b1;
              pend_slot  <= 4'(idx);
              pend_len   <= rd_len;
              if (pend_valid) begin
                fired_slot   <= pend_slot;
                fired_length <= pend_len;
                last         <= 1'b0;
              end
            end
          end else if (!hit && !late && idx != cnt) begin
            idx <= idx + CW'(1);
          end
        end
        ST_CATCH: begin
          idx <= idx + CW'(1);
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid   <= 1'b0;
            fired_slot   <= pend_slot;
            fired_length <= pend_len;
            last         <= 1'b1;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  assign status.idle  = (state == ST_IDLE);
  assign status.count = cnt;

endmodule

@@ verif/periodic_daily_alarm_table_tb.sv @@
`timescale 1ns / 1ps
module periodic_daily_alarm_table_tb;
  import pdat_pkg::*;

  // one expected firing
  typedef struct {
    logic [3:0]  fired_slot;
    logic [15:0] fired_length;
    logic        last;
  } firing_t;

  // alarm table predictor and firing checker
  class alarm_scoreboard;
    logic [16:0] interval;
    logic [16:0] start_sec [MAX_ENTRIES];
    logic [15:0] length_sec [MAX_ENTRIES];
    logic [16:0] offset_sec [MAX_ENTRIES];
    int count;
    firing_t pending_firings[$];
    int mismatches;
    int firings_seen;

    function new();
      interval = '0;
      count = 0;
      mismatches = 0;
      firings_seen = 0;
    endfunction

    function logic [16:0] step_offset(int i, int unsigned at, int unsigned stride);
      if (at + stride < 86400) return 17'(offset_sec[i] + stride);
      return '0;
    endfunction

    // apply one accepted transaction to the table
    function void note_command(op_t o, logic [16:0] now, logic [3:0] s,
                               logic [16:0] first, logic [15:0] len);
      int unsigned pos;
      int unsigned run;
      int unsigned k;
      int n;
      int lastidx;
      pos = s;
      n = 0;
      lastidx = -1;
      case (o)
        OP_INSERT: begin
          if (count < MAX_ENTRIES) begin
            if (pos > count) pos = count;
            for (int i = count; i > pos; i--) begin
              start_sec[i] = start_sec[i-1];
              length_sec[i] = length_sec[i-1];
              offset_sec[i] = offset_sec[i-1];
            end
            start_sec[pos] = first;
            length_sec[pos] = len;
            offset_sec[pos] = '0;
            count++;
          end
        end
        OP_REMOVE: begin
          if (pos < count) begin
            for (int i = pos; i + 1 < count; i++) begin
              start_sec[i] = start_sec[i+1];
              length_sec[i] = length_sec[i+1];
              offset_sec[i] = offset_sec[i+1];
            end
            count--;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < count; i++) offset_sec[i] = '0;
        end
        default: begin
          for (int i = 0; i < count; i++) begin
            run = start_sec[i] + offset_sec[i];
            if (run == now) begin
              firing_t f;
              f.fired_slot = 4'(i);
              f.fired_length = length_sec[i];
              f.last = 1'b0;
              pending_firings = {pending_firings, f};
              lastidx = pending_firings.size() - 1;
              if (interval != 0) offset_sec[i] = step_offset(i, run, interval);
            end else if (interval != 0 && run < now) begin
              k = (now - run + interval - 1) / interval;
              offset_sec[i] = step_offset(i, run, k * interval);
            end
          end
          if (lastidx >= 0) pending_firings[lastidx].last = 1'b1;
        end
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_firing(logic [3:0] fs, logic [15:0] fl, logic lf);
      firing_t e;
      firings_seen++;
      if (pending_firings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected firing slot=%0d len=%0d last=%0b", fs, fl, lf);
        return;
      end
      e = pending_firings.pop_front();
      if (e.fired_slot !== fs || e.fired_length !== fl || e.last !== lf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("firing mismatch: exp slot=%0d len=%0d last=%0b, got slot=%0d len=%0d last=%0b",
                   e.fired_slot, e.fired_length, e.last, fs, fl, lf);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write_en;
  logic [16:0] cfg_write_data;
  logic in_valid, in_ready;
  logic [1:0] op;
  logic [16:0] now_seconds;
  logic [3:0] slot;
  logic [16:0] first_second;
  logic [15:0] run_length;
  logic out_valid, out_ready;
  logic [3:0] fired_slot;
  logic [15:0] fired_length;
  logic last;

  alarm_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  int unsigned cycle_count;
  int items_sent;

  periodic_daily_alarm_table i_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .now_seconds(now_seconds), .slot(slot),
    .first_second(first_second), .run_length(run_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .fired_slot(fired_slot), .fired_length(fired_length), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver with random stalls, checks each accepted transaction
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_firing(fired_slot, fired_length, last);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one transaction, with a random gap first
  task automatic send_cmd(op_t o, logic [16:0] now, logic [3:0] s,
                          logic [16:0] first, logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    now_seconds <= now;
    slot <= s;
    first_second <= first;
    run_length <= len;
    do @(posedge clk); while (!in_ready);
    sb.note_command(o, now, s, first, len);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_firings.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_interval(logic [16:0] v);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.interval = v;
  endtask

  // random time, biased toward entry run times so ticks fire
  function automatic logic [16:0] pick_time();
    int unsigned i;
    if (sb.count != 0 && $urandom_range(99) < 60) begin
      i = $urandom_range(sb.count - 1);
      return 17'(sb.start_sec[i] + sb.offset_sec[i] + ($urandom_range(3) == 0 ? 1 : 0));
    end
    if ($urandom_range(9) == 0) return 17'($urandom);
    return 17'($urandom_range(86399));
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55 || (sb.count == MAX_ENTRIES && r < 70))
      send_cmd(OP_TICK, pick_time(), 4'($urandom), 17'($urandom), 16'($urandom));
    else if (r < 80)
      send_cmd(OP_INSERT, 17'($urandom), 4'($urandom), 17'($urandom_range(86399)),
               16'($urandom));
    else if (r < 94)
      send_cmd(OP_REMOVE, 17'($urandom), 4'($urandom), 17'($urandom), 16'($urandom));
    else
      send_cmd(OP_CLEAR, 17'($urandom), 4'($urandom), 17'($urandom), 16'($urandom));
  endtask

  // main stimulus sequence
  initial begin
    logic [16:0] intervals [5] = '{17'd1, 17'd86399, 17'd3600, 17'd0, 17'd7};
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    op = OP_TICK;
    now_seconds = '0;
    slot = '0;
    first_second = '0;
    run_length = '0;
    items_sent = 0;
    send_idle_pct = 28;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, full table, out of range cases
    send_cmd(OP_TICK, 17'd0, 4'd0, 17'd0, 16'd0);
    send_cmd(OP_REMOVE, 17'd0, 4'd0, 17'd0, 16'd0);
    send_cmd(OP_INSERT, 17'd0, 4'd15, 17'd0, 16'hFFFF);
    send_cmd(OP_INSERT, 17'd0, 4'd0, 17'd86399, 16'd0);
    send_cmd(OP_TICK, 17'd0, 4'd0, 17'd0, 16'd0);
    send_cmd(OP_TICK, 17'd86399, 4'd0, 17'd0, 16'd0);
    send_cmd(OP_TICK, 17'h1FFFF, 4'd0, 17'd0, 16'd0);
    for (int i = 0; i < 15; i++)
      send_cmd(OP_INSERT, 17'd0, 4'($urandom), 17'd500, 16'(i + 1));
    send_cmd(OP_INSERT, 17'd0, 4'd3, 17'd500, 16'h1234);
    send_cmd(OP_TICK, 17'd500, 4'd0, 17'd0, 16'd0);
    send_cmd(OP_REMOVE, 17'd0, 4'd15, 17'd0, 16'd0);
    send_cmd(OP_CLEAR, 17'd0, 4'd0, 17'd0, 16'd0);

    // sweep the interval through its settings and idle patterns
    for (int p = 0; p < 5; p++) begin
      write_interval(intervals[p]);
      if (p == 2) begin send_idle_pct = 64; recv_idle_pct = 28; end
      if (p == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_cmd(OP_TICK, 17'h1FFFF, 4'd0, 17'd0, 16'd0);
      for (int j = 0; j < 88; j++) begin
        if (j == 50) drain();
        random_item();
      end
    end

    drain();
    $display("sent %0d transactions, checked %0d firings over 5 interval settings",
             items_sent, sb.firings_seen);
    if (sb.mismatches == 0 && sb.pending_firings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d firings missing", sb.mismatches, sb.pending_firings.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
